@@ hdl/rbd_pkg.sv @@
// Package for the ring buffer deque: field widths, operation and status codes,
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package rbd_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_GET     = 3'd0,
    FN_PUT     = 3'd1,
    FN_PUSH_HI = 3'd2,
    FN_PUSH_LO = 3'd3,
    FN_POP_HI  = 3'd4,
    FN_POP_LO  = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // controller -> datapath
  typedef struct packed {
    logic latch;   // capture request fields
    logic rd_en;   // read the addressed entry
    logic commit;  // write entry, update pointers, load result
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;  // result register can take a new item this cycle
  } stat_t;

endpackage

`default_nettype wire

@@ hdl/rbd_if.sv @@
// Valid/ready channel interfaces for the ring buffer deque: request and response.
// Depends on rbd_pkg for field widths.
`default_nettype none

interface rbd_req_if;
  logic                         valid;
  logic                         ready;
  logic [rbd_pkg::FUNC_W-1:0]   func;
  logic [rbd_pkg::INDEX_W-1:0]  index;
  logic [rbd_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output func, output index, output value, input ready);
  modport sink   (input valid, input func, input index, input value, output ready);
endinterface

interface rbd_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [rbd_pkg::DATA_W-1:0]   data;
  logic [rbd_pkg::COUNT_W-1:0]  count;
  logic [rbd_pkg::STATUS_W-1:0] status;

  modport source (output valid, output data, output count, output status, input ready);
  modport sink   (input valid, input data, input count, input status, output ready);
endinterface

`default_nettype wire

@@ hdl/rbd_ram.sv @@
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`default_nettype none

module rbd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/rbd_ctrl.sv @@
// Controller for the ring buffer deque: accept, read, commit sequence.
// Depends on rbd_pkg (cmd_t, stat_t).
`default_nettype none

module rbd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rbd_pkg::stat_t stat_i,
  output rbd_pkg::cmd_t  cmd_o
);
  import rbd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd_d;

  always_comb begin
    state_d = state_q;
    cmd_d   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d.latch = 1'b1;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        cmd_d.rd_en = 1'b1;
        state_d     = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the result register has room
        if (stat_i.slot_free) begin
          cmd_d.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd_d;

endmodule

`default_nettype wire

@@ hdl/rbd_dpath.sv @@
// Datapath for the ring buffer deque: request register, pointers, store, result register.
// Depends on rbd_pkg and rbd_ram.
`default_nettype none

module rbd_dpath #(
  parameter int unsigned DEPTH      = rbd_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rbd_pkg::cmd_t                 cmd_i,
  output rbd_pkg::stat_t                stat_o,
  input  logic [rbd_pkg::FUNC_W-1:0]    func_i,
  input  logic [rbd_pkg::INDEX_W-1:0]   index_i,
  input  logic [rbd_pkg::VALUE_W-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rbd_pkg::DATA_W-1:0]    data_o,
  output logic [rbd_pkg::COUNT_W-1:0]   count_o,
  output logic [rbd_pkg::STATUS_W-1:0]  status_o
);
  import rbd_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam logic [PTR_W:0]   DEPTH_S = (PTR_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

  // head + offset modulo DEPTH; both operands stay below DEPTH
  function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                               input logic [PTR_W-1:0] off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[PTR_W-1:0];
  endfunction

  logic [FUNC_W-1:0]     func_q;
  logic [INDEX_W-1:0]    index_q;
  logic [DATA_WIDTH-1:0] value_q;
  logic [PTR_W-1:0]      head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  out_valid_q;
  logic [DATA_W-1:0]     data_q;
  logic [COUNT_W-1:0]    count_out_q;
  logic [STATUS_W-1:0]   status_q;

  logic [PTR_W-1:0]      addr;
  logic [PTR_W-1:0]      head_dec, head_inc;
  logic [CNT_W-1:0]      count_m1;
  logic [DATA_WIDTH-1:0] rdata;
  logic [DATA_W-1:0]     res_data;
  status_e               status_c;
  logic                  wr;
  logic                  range_bad, full, empty;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q  <= func_i;
      index_q <= index_i;
      value_q <= DATA_WIDTH'(value_i);
    end
  end

  assign head_dec  = (head_q == '0) ? LAST_P : head_q - 1'b1;
  assign head_inc  = (head_q == LAST_P) ? '0 : head_q + 1'b1;
  assign count_m1  = count_q - 1'b1;
  assign range_bad = CMP_W'(index_q) >= CMP_W'(count_q);
  assign full      = (count_q == DEPTH_C);
  assign empty     = (count_q == '0);

  always_comb begin
    status_c = ST_OK;
    addr     = head_q;
    wr       = 1'b0;
    head_d   = head_q;
    count_d  = count_q;
    res_data = '0;
    unique case (func_e'(func_q))
      FN_GET, FN_PUT: begin
        addr = wrap_add(head_q, PTR_W'(index_q));
        if (range_bad) begin
          status_c = ST_RANGE;
        end else begin
          res_data = DATA_W'(rdata);
          wr       = (func_e'(func_q) == FN_PUT);
        end
      end
      FN_PUSH_HI: begin
        addr = wrap_add(head_q, PTR_W'(count_q));
        if (full) begin
          status_c = ST_FULL;
        end else begin
          wr       = 1'b1;
          count_d  = count_q + 1'b1;
          res_data = DATA_W'(value_q);
        end
      end
      FN_PUSH_LO: begin
        addr = head_dec;
        if (full) begin
          status_c = ST_FULL;
        end else begin
          wr       = 1'b1;
          head_d   = head_dec;
          count_d  = count_q + 1'b1;
          res_data = DATA_W'(value_q);
        end
      end
      FN_POP_HI: begin
        addr = wrap_add(head_q, PTR_W'(count_m1));
        if (empty) begin
          status_c = ST_EMPTY;
        end else begin
          count_d  = count_m1;
          res_data = DATA_W'(rdata);
        end
      end
      FN_POP_LO: begin
        addr = head_q;
        if (empty) begin
          status_c = ST_EMPTY;
        end else begin
          head_d   = head_inc;
          count_d  = count_m1;
          res_data = DATA_W'(rdata);
        end
      end
      default: ;  // unused codes: no change, status ok
    endcase
  end

  rbd_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit && wr),
    .waddr_i (addr),
    .wdata_i (value_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      data_q      <= res_data;
      count_out_q <= COUNT_W'(count_d);
      status_q    <= status_c;
    end
  end

  assign stat_o.slot_free = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign data_o           = data_q;
  assign count_o          = count_out_q;
  assign status_o         = status_q;

  a_state_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= DEPTH_C) && ({1'b0, head_q} < DEPTH_S))
    else $error("deque pointer or count out of bounds");

  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!out_valid_q || out_ready_i))
    else $error("commit while result register occupied");

  a_refused_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (status_c != ST_OK)) |=>
      (head_q == $past(head_q)) && (count_q == $past(count_q)))
    else $error("refused operation changed deque state");

  a_idle_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(head_q) && $stable(count_q))
    else $error("deque state changed without commit");

endmodule

`default_nettype wire

@@ hdl/ring_buffer_deque.sv @@
// Top level of the ring buffer deque: controller, datapath and channel glue.
// Depends on rbd_pkg, rbd_if, rbd_ctrl, rbd_dpath (and rbd_ram below it).
`default_nettype none

// Double-ended queue of DEPTH entries, DATA_WIDTH bits each, held in a
// circular store addressed from a head pointer plus a logical index. Each
// request item carries one operation (get, put, push high/low, pop high/low)
// and yields exactly one response item with the data, the count after the
// operation and a status code. Refused requests (push when full, pop when
// empty, get/put index not below count) leave the queue untouched and return
// zero data. Unused operation codes return status ok and change nothing.
// Timing: an item passes through accept, store read and commit in turn; its
// result is registered at the commit, after the store's registered read;
// the commit waits while the output register is still occupied. A new
// request is taken on the cycle after the commit, even while the previous
// result still waits in the output register, but no new request is taken
// before the current item is committed.
// The store has no reset and no clearing pass; only entries written by a
// push are ever returned, so the block is ready right after reset.
module ring_buffer_deque #(
  parameter int unsigned DEPTH      = rbd_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rbd_req_if.sink      req_i,
  rbd_rsp_if.source    rsp_o
);
  import rbd_pkg::*;

  cmd_t  cmd;   // sequencing commands
  stat_t stat;  // result register occupancy

  logic                in_ready;
  logic                out_valid;
  logic [DATA_W-1:0]   out_data;
  logic [COUNT_W-1:0]  out_count;
  logic [STATUS_W-1:0] out_status;

  // Controller: idle -> read -> commit, holds in commit while the response
  // side is stalled with a result still pending.
  rbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: request capture, address arithmetic with wrap, store,
  // head/count registers and the response register.
  rbd_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .func_i      (req_i.func),
    .index_i     (req_i.index),
    .value_i     (req_i.value),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .data_o      (out_data),
    .count_o     (out_count),
    .status_o    (out_status)
  );

  assign req_i.ready  = in_ready;
  assign rsp_o.valid  = out_valid;
  assign rsp_o.data   = out_data;
  assign rsp_o.count  = out_count;
  assign rsp_o.status = out_status;

endmodule

`default_nettype wire

@@ tb/tb_ring_buffer_deque.sv @@
// Self-checking testbench for ring_buffer_deque: drives request items and checks every
// response against a predictor of the deque kept inside this file.
// Depends on rbd_pkg, rbd_if and the ring_buffer_deque RTL.
`timescale 1ns / 1ps

module tb_ring_buffer_deque;
  import rbd_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_DEF;
  localparam int unsigned PTR_W       = INDEX_W;
  localparam int unsigned LATENCY     = 3;        // accept, store read, commit
  localparam int unsigned HOLD_CYCLES = 300;      // long response hold-off
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RAND_ITEMS  = 1750;

  // operation codes the package leaves unnamed; the block must ignore them
  localparam logic [FUNC_W-1:0] FN_RSVD_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD_7 = 3'd7;

  // receiver behavior between hold-offs
  localparam int RX_STEADY  = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;

  // operation mix of a random burst
  localparam int BIAS_FILL  = 0;
  localparam int BIAS_DRAIN = 1;
  localparam int BIAS_EVEN  = 2;

  typedef struct packed {
    logic [DATA_W-1:0]   data;
    logic [COUNT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
  } deque_result_t;

  logic clk;
  logic rst_n;

  rbd_req_if req_if ();
  rbd_rsp_if rsp_if ();

  ring_buffer_deque u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Deque predictor: a private copy of the store, head pointer and fill count.
  // Advanced once per accepted request, in acceptance order.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0]  model_store [DEPTH];
  logic [PTR_W-1:0]   model_head;
  logic [COUNT_W-1:0] model_fill;

  deque_result_t pending_results[$];   // expected responses, oldest first

  int failures;
  int cycle_count;
  int hold_requests;                   // bumped by a test to ask for a hold-off

  function automatic deque_result_t apply_deque_op(input logic [FUNC_W-1:0]  func,
                                                   input logic [INDEX_W-1:0] idx,
                                                   input logic [VALUE_W-1:0] value);
    deque_result_t res;
    logic [PTR_W-1:0] pos;
    res.data   = '0;
    res.status = ST_OK;
    case (func)
      FN_GET, FN_PUT: begin
        // index must address a held entry; otherwise nothing changes
        if ({1'b0, idx} >= model_fill) begin
          res.status = ST_RANGE;
        end else begin
          pos      = model_head + idx;
          res.data = model_store[pos];
          if (func == FN_PUT) model_store[pos] = value;
        end
      end
      FN_PUSH_HI, FN_PUSH_LO: begin
        if (model_fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          if (func == FN_PUSH_HI) begin
            pos = model_head + model_fill[PTR_W-1:0];
          end else begin
            // low end grows downward, wrapping below zero
            model_head = model_head - 1'b1;
            pos        = model_head;
          end
          model_store[pos] = value;
          model_fill       = model_fill + 1'b1;
          res.data         = value;
        end
      end
      FN_POP_HI, FN_POP_LO: begin
        if (model_fill == 0) begin
          res.status = ST_EMPTY;
        end else if (func == FN_POP_HI) begin
          model_fill = model_fill - 1'b1;
          pos        = model_head + model_fill[PTR_W-1:0];
          res.data   = model_store[pos];
        end else begin
          res.data   = model_store[model_head];
          model_head = model_head + 1'b1;
          model_fill = model_fill - 1'b1;
        end
      end
      default: ;  // unused codes: status ok, nothing moves
    endcase
    res.count = model_fill;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Fields change at the falling edge; acceptance is seen at the
  // rising edge. Valid stays high on return so back-to-back items need no gap.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [FUNC_W-1:0]  func,
                           input logic [INDEX_W-1:0] idx,
                           input logic [VALUE_W-1:0] value);
    @(negedge clk);
    req_if.valid = 1'b1;
    req_if.func  = func;
    req_if.index = idx;
    req_if.value = value;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_results.push_back(apply_deque_op(func, idx, value));
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      req_if.valid = 1'b0;
    end
  endtask

  // One random item. Get/put indices mostly land on held entries so the
  // store is exercised; the rest may fall out of range.
  task automatic send_random_item(input int bias);
    int r;
    int push_w;
    int pop_w;
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] idx;
    logic [VALUE_W-1:0] value;
    push_w = (bias == BIAS_FILL) ? 55 : (bias == BIAS_DRAIN) ? 15 : 35;
    pop_w  = (bias == BIAS_DRAIN) ? 55 : (bias == BIAS_FILL) ? 15 : 35;
    r = $urandom_range(0, 99);
    if (r < 3)
      func = $urandom_range(0, 1) ? FN_RSVD_6 : FN_RSVD_7;
    else if (r < 3 + push_w)
      func = $urandom_range(0, 1) ? FN_PUSH_HI : FN_PUSH_LO;
    else if (r < 3 + push_w + pop_w)
      func = $urandom_range(0, 1) ? FN_POP_HI : FN_POP_LO;
    else
      func = $urandom_range(0, 1) ? FN_GET : FN_PUT;
    if (model_fill != 0 && $urandom_range(0, 9) != 0)
      idx = INDEX_W'($urandom_range(0, model_fill - 1));
    else
      idx = INDEX_W'($urandom_range(0, DEPTH - 1));
    case ($urandom_range(0, 7))
      0:       value = '0;
      1:       value = '1;
      default: value = $urandom;
    endcase
    send_item(func, idx, value);
  endtask

  task automatic wait_results_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Response side. Ready follows a mode that changes every so often (steady,
  // random, fixed 8-bit pattern); a hold-off request overrides it.
  // ---------------------------------------------------------------------------
  int       rx_mode;
  int       rx_left;
  int       hold_left;
  int       holds_served;
  logic [7:0] rx_pattern;
  logic [2:0] rx_phase;

  always @(negedge clk) begin
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (rx_left == 0) begin
      rx_mode    = $urandom_range(RX_STEADY, RX_PATTERN);
      rx_left    = $urandom_range(20, 200);
      rx_pattern = 8'($urandom_range(1, 255));
    end else begin
      rx_left = rx_left - 1;
    end
    if (hold_left != 0) begin
      hold_left    = hold_left - 1;
      rsp_if.ready = 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: rsp_if.ready = 1'b1;
        RX_RANDOM: rsp_if.ready = ($urandom_range(0, 3) != 0);
        default:   rsp_if.ready = rx_pattern[rx_phase];
      endcase
    end
    rx_phase = rx_phase + 1'b1;
  end

  // Scoreboard: each accepted response against the oldest expectation.
  always @(posedge clk) begin
    deque_result_t exp_res;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        failures = failures + 1;
        if (failures <= 10)
          $display("unexpected response: data=%h count=%0d status=%0d",
                   rsp_if.data, rsp_if.count, rsp_if.status);
      end else begin
        exp_res = pending_results.pop_front();
        if (exp_res.data !== rsp_if.data || exp_res.count !== rsp_if.count ||
            exp_res.status !== rsp_if.status) begin
          failures = failures + 1;
          if (failures <= 10)
            $display("mismatch: exp data=%h count=%0d status=%0d, got data=%h count=%0d status=%0d",
                     exp_res.data, exp_res.count, exp_res.status,
                     rsp_if.data, rsp_if.count, rsp_if.status);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ring_buffer_deque test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh queue: every access is refused; unused codes just report status ok.
  task automatic test_empty_refusals();
    send_item(FN_GET,     4'd0,  32'h0000_0000);
    send_item(FN_PUT,     4'd15, 32'hFFFF_FFFF);
    send_item(FN_POP_HI,  4'd0,  32'h0000_0000);
    send_item(FN_POP_LO,  4'd0,  32'h0000_0000);
    send_item(FN_RSVD_6,  4'd5,  32'hA5A5_A5A5);
    send_item(FN_RSVD_7,  4'd10, 32'h5A5A_5A5A);
  endtask

  // Low-end pushes wrap the head below zero; then fill to capacity, try both
  // pushes when full, and touch the extreme indices.
  task automatic test_fill_to_capacity();
    send_item(FN_PUSH_LO, 4'd0, 32'h0000_0000);
    send_item(FN_PUSH_LO, 4'd0, 32'hFFFF_FFFF);
    repeat (DEPTH - 2) send_item(FN_PUSH_HI, INDEX_W'($urandom_range(0, 15)), $urandom);
    send_item(FN_PUSH_HI, 4'd0,  32'h1234_5678);
    send_item(FN_PUSH_LO, 4'd0,  32'h8765_4321);
    send_item(FN_GET,     4'd0,  32'h0000_0000);
    send_item(FN_GET,     4'd15, 32'h0000_0000);
    send_item(FN_PUT,     4'd15, 32'hFFFF_FFFF);
    send_item(FN_PUT,     4'd0,  32'h0000_0000);
    send_item(FN_GET,     4'd15, 32'h0000_0000);
    send_item(FN_POP_HI,  4'd0,  32'h0000_0000);
    send_item(FN_POP_LO,  4'd0,  32'h0000_0000);
  endtask

  // Bursts of random operations with random gaps; each burst leans toward
  // filling, draining or neither so both full and empty get visited often.
  task automatic test_random_traffic(input int n_items);
    int sent;
    int burst;
    int bias;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 40);
      bias  = $urandom_range(BIAS_FILL, BIAS_EVEN);
      repeat (burst) send_random_item(bias);
      sent = sent + burst;
      idle_cycles($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12));
    end
  endtask

  // Response side holds off for a long stretch while requests keep coming:
  // the block must stall its input instead of dropping results.
  task automatic test_output_backpressure();
    @(posedge clk);
    hold_requests = hold_requests + 1;
    repeat (40) send_random_item(BIAS_EVEN);
  endtask

  // Sender waits for every outstanding result before carrying on.
  task automatic test_drain_pause();
    idle_cycles(1);
    wait_results_drained();
    repeat (40) send_random_item(BIAS_EVEN);
  endtask

  initial begin
    rst_n         = 1'b0;
    req_if.valid  = 1'b0;
    req_if.func   = '0;
    req_if.index  = '0;
    req_if.value  = '0;
    rsp_if.ready  = 1'b0;
    failures      = 0;
    cycle_count   = 0;
    hold_requests = 0;
    holds_served  = 0;
    hold_left     = 0;
    rx_mode       = RX_STEADY;
    rx_left       = 0;
    rx_pattern    = 8'hFF;
    rx_phase      = '0;
    model_head    = '0;
    model_fill    = '0;
    foreach (model_store[k]) model_store[k] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_refusals();
    test_fill_to_capacity();
    test_random_traffic(RAND_ITEMS / 2);
    test_output_backpressure();
    test_random_traffic(RAND_ITEMS / 2);
    test_drain_pause();

    // let the last results out, then wait for stragglers
    idle_cycles(1);
    wait_results_drained();
    repeat (LATENCY + 3) @(posedge clk);

    if (failures == 0 && pending_results.size() == 0) begin
      $display("ring_buffer_deque test passed");
    end else begin
      $display("ring_buffer_deque test failed");
    end
    $finish;
  end

endmodule
